// File: hdl/lc3_exec_pkg.sv
`default_nettype none

package lc3_exec_pkg;

   // Memory address width used when the top level is not told otherwise.
   localparam int unsigned ADDR_BITS_DEFAULT = 16;

   localparam logic [15:0] RESET_PC = 16'h3000;

   // One-hot condition code.
   localparam logic [2:0] FLAG_P = 3'b001;
   localparam logic [2:0] FLAG_Z = 3'b010;
   localparam logic [2:0] FLAG_N = 3'b100;

   // Request function codes.
   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_EXEC    = 2'd1;
   localparam logic [1:0] FUNC_RESTART = 2'd2;

   // Opcodes.
   localparam logic [3:0] OP_BR   = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_LD   = 4'd2;
   localparam logic [3:0] OP_ST   = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_LDR  = 4'd6;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_RTI  = 4'd8;
   localparam logic [3:0] OP_NOT  = 4'd9;
   localparam logic [3:0] OP_LDI  = 4'd10;
   localparam logic [3:0] OP_STI  = 4'd11;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_RES  = 4'd13;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   // Payload of one response transaction.
   typedef struct packed {
      logic [15:0] pc_after;
      logic [15:0] executed_word;
      logic [2:0]  flags;
      logic        reg_written;
      logic [2:0]  reg_number;
      logic [15:0] reg_value;
      logic        mem_written;
      logic [15:0] store_addr;
      logic [15:0] store_data;
      logic        illegal;
   } rsp_fields_type;

endpackage

`default_nettype wire

// File: hdl/lc3_exec_if.sv
`default_nettype none

interface lc3_exec_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] load_addr;
   logic [15:0] load_data;

   modport source (output valid, output func, output load_addr, output load_data,
                   input ready);
   modport sink (input valid, input func, input load_addr, input load_data,
                 output ready);
endinterface

interface lc3_exec_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pc_after;
   logic [15:0] executed_word;
   logic [2:0]  flags;
   logic        reg_written;
   logic [2:0]  reg_number;
   logic [15:0] reg_value;
   logic        mem_written;
   logic [15:0] store_addr;
   logic [15:0] store_data;
   logic        illegal;

   modport source (output valid, output pc_after, output executed_word, output flags,
                   output reg_written, output reg_number, output reg_value,
                   output mem_written, output store_addr, output store_data,
                   output illegal, input ready);
   modport sink (input valid, input pc_after, input executed_word, input flags,
                 input reg_written, input reg_number, input reg_value,
                 input mem_written, input store_addr, input store_data,
                 input illegal, output ready);
endinterface

`default_nettype wire

// File: hdl/lc3_instruction_executor_core.sv
`default_nettype none

// Channel    Direction  Handshake      Payload
// req_ch     in         valid/ready    func, load_addr, load_data
// rsp_ch     out        valid/ready    pc_after .. illegal, one per request
// csr_*      in         csr_we         csr_wdata (start PC)
//
// A load, restart or unused request passes through S_FIN; an instruction steps through
// S_DECODE, S_REGA, S_EXEC and S_WB, with S_MEM1 before S_WB for LDI, set by the one read
// port of the word memory and of the register file, walked one access at a time.
// After reset a clearing pass zeroes the memory, one word a cycle, over all
// 2**ADDR_BITS words; requests are held off meanwhile, CSR writes are taken.
// A response still waiting to be taken holds back only the final step of the next request.

module lc3_instruction_executor_core #(
   parameter int unsigned ADDR_BITS = lc3_exec_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lc3_exec_req_if.sink     req_ch,
   lc3_exec_rsp_if.source   rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   localparam int unsigned MEM_DEPTH = 2 ** ADDR_BITS;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_REGA   = 3'd3;
   localparam logic [2:0] S_EXEC   = 3'd4;
   localparam logic [2:0] S_MEM1   = 3'd5;
   localparam logic [2:0] S_WB     = 3'd6;
   localparam logic [2:0] S_FIN    = 3'd7;

   function automatic logic [2:0] cc_of(input logic [15:0] v);
      logic [2:0] r;
      if (v == 16'h0000) begin
         r = lc3_exec_pkg::FLAG_Z;
      end else if (v[15]) begin
         r = lc3_exec_pkg::FLAG_N;
      end else begin
         r = lc3_exec_pkg::FLAG_P;
      end
      return r;
   endfunction

   // Storage
   logic [15:0] word_mem [MEM_DEPTH];
   logic [15:0] gen_reg [8];

   logic [15:0] mem_rdata_ff;
   logic [15:0] rf_q_ff;

   // Control and datapath registers
   logic [2:0]           state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [15:0]          pc_ff, pc_in;
   logic [2:0]           cc_ff, cc_in;
   logic [15:0]          start_pc_ff, start_pc_in;
   logic [15:0]          ir_ff, ir_in;
   logic [15:0]          a_ff, a_in;
   logic [15:0]          ea_ff, ea_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lc3_exec_pkg::rsp_fields_type rsp_ff, rsp_in;

   // Memory and register file ports
   logic                 mem_we, mem_re;
   logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
   logic [15:0]          mem_wdata;
   logic                 rf_we, rf_re;
   logic [2:0]           rf_waddr, rf_raddr;
   logic [15:0]          rf_wdata;

   // Instruction fields
   logic [3:0]  op;
   logic [15:0] off9, off11, off6, imm5, b_opnd;
   logic        out_free, req_ready;

   lc3_exec_pkg::rsp_fields_type exe;
   logic [15:0] wb_pc;
   logic        wb_setcc;

   assign op    = ir_ff[15:12];
   assign off9  = {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign off11 = {{5{ir_ff[10]}}, ir_ff[10:0]};
   assign off6  = {{10{ir_ff[5]}}, ir_ff[5:0]};
   assign imm5  = {{11{ir_ff[4]}}, ir_ff[4:0]};
   assign b_opnd = ir_ff[5] ? imm5 : rf_q_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Outcome of the instruction at write-back, from the latched operands.
   always_comb begin
      exe = '0;
      exe.executed_word = ir_ff;
      wb_pc = pc_ff;
      wb_setcc = 1'b0;
      case (op)
         lc3_exec_pkg::OP_BR: begin
            if ((ir_ff[11] && cc_ff[2]) || (ir_ff[10] && cc_ff[1]) ||
                (ir_ff[9] && cc_ff[0])) begin
               wb_pc = pc_ff + off9;
            end
         end
         lc3_exec_pkg::OP_ADD, lc3_exec_pkg::OP_AND, lc3_exec_pkg::OP_NOT: begin
            exe.reg_written = 1'b1;
            exe.reg_number = ir_ff[11:9];
            if (op == lc3_exec_pkg::OP_ADD) begin
               exe.reg_value = a_ff + b_opnd;
            end else if (op == lc3_exec_pkg::OP_AND) begin
               exe.reg_value = a_ff & b_opnd;
            end else begin
               exe.reg_value = ~a_ff;
            end
            wb_setcc = 1'b1;
         end
         lc3_exec_pkg::OP_LD, lc3_exec_pkg::OP_LDR, lc3_exec_pkg::OP_LDI: begin
            exe.reg_written = 1'b1;
            exe.reg_number = ir_ff[11:9];
            exe.reg_value = mem_rdata_ff;
            wb_setcc = 1'b1;
         end
         lc3_exec_pkg::OP_LEA: begin
            exe.reg_written = 1'b1;
            exe.reg_number = ir_ff[11:9];
            exe.reg_value = ea_ff;
            wb_setcc = 1'b1;
         end
         lc3_exec_pkg::OP_ST, lc3_exec_pkg::OP_STR: begin
            exe.mem_written = 1'b1;
            exe.store_addr = ea_ff;
            exe.store_data = rf_q_ff;
         end
         lc3_exec_pkg::OP_STI: begin
            exe.mem_written = 1'b1;
            exe.store_addr = mem_rdata_ff;
            exe.store_data = rf_q_ff;
         end
         lc3_exec_pkg::OP_JMP: begin
            wb_pc = a_ff;
         end
         lc3_exec_pkg::OP_JSR: begin
            exe.reg_written = 1'b1;
            exe.reg_number = 3'd7;
            exe.reg_value = pc_ff;
            wb_pc = ir_ff[11] ? pc_ff + off11 : a_ff;
         end
         lc3_exec_pkg::OP_TRAP: begin
            exe.reg_written = 1'b1;
            exe.reg_number = 3'd7;
            exe.reg_value = pc_ff;
            wb_pc = mem_rdata_ff;
         end
         default: begin
            exe.illegal = 1'b1;
         end
      endcase
      exe.pc_after = wb_pc;
      exe.flags = wb_setcc ? cc_of(exe.reg_value) : cc_ff;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      pc_in = pc_ff;
      cc_in = cc_ff;
      ir_in = ir_ff;
      a_in = a_ff;
      ea_in = ea_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re = 1'b0;
      mem_raddr = '0;
      rf_we = 1'b0;
      rf_waddr = '0;
      rf_wdata = '0;
      rf_re = 1'b0;
      rf_raddr = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            rf_we = 1'b1;
            rf_waddr = clr_ff[2:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == {ADDR_BITS{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               state_in = S_FIN;
               case (req_ch.func)
                  lc3_exec_pkg::FUNC_LOAD: begin
                     mem_we = 1'b1;
                     mem_waddr = req_ch.load_addr[ADDR_BITS-1:0];
                     mem_wdata = req_ch.load_data;
                  end
                  lc3_exec_pkg::FUNC_EXEC: begin
                     mem_re = 1'b1;
                     mem_raddr = pc_ff[ADDR_BITS-1:0];
                     state_in = S_DECODE;
                  end
                  lc3_exec_pkg::FUNC_RESTART: begin
                     pc_in = start_pc_ff;
                     cc_in = lc3_exec_pkg::FLAG_Z;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DECODE: begin
            ir_in = mem_rdata_ff;
            pc_in = pc_ff + 16'd1;
            rf_re = 1'b1;
            rf_raddr = mem_rdata_ff[8:6];
            state_in = S_REGA;
         end
         S_REGA: begin
            a_in = rf_q_ff;
            rf_re = 1'b1;
            rf_raddr = (op == lc3_exec_pkg::OP_ADD || op == lc3_exec_pkg::OP_AND) ?
                       ir_ff[2:0] : ir_ff[11:9];
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (op == lc3_exec_pkg::OP_LDR || op == lc3_exec_pkg::OP_STR) begin
               ea_in = a_ff + off6;
            end else begin
               ea_in = pc_ff + off9;
            end
            if (op inside {lc3_exec_pkg::OP_LD, lc3_exec_pkg::OP_LDR,
                           lc3_exec_pkg::OP_LDI, lc3_exec_pkg::OP_STI}) begin
               mem_re = 1'b1;
               mem_raddr = ea_in[ADDR_BITS-1:0];
            end else if (op == lc3_exec_pkg::OP_TRAP) begin
               mem_re = 1'b1;
               mem_raddr = ADDR_BITS'(ir_ff[7:0]);
            end
            state_in = (op == lc3_exec_pkg::OP_LDI) ? S_MEM1 : S_WB;
         end
         S_MEM1: begin
            // Second, indirect read of LDI through the pointer just fetched.
            mem_re = 1'b1;
            mem_raddr = mem_rdata_ff[ADDR_BITS-1:0];
            state_in = S_WB;
         end
         S_WB: begin
            if (out_free) begin
               rsp_in = exe;
               rsp_valid_in = 1'b1;
               pc_in = wb_pc;
               cc_in = exe.flags;
               rf_we = exe.reg_written;
               rf_waddr = exe.reg_number;
               rf_wdata = exe.reg_value;
               mem_we = exe.mem_written;
               mem_waddr = exe.store_addr[ADDR_BITS-1:0];
               mem_wdata = exe.store_data;
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_in = '0;
               rsp_in.pc_after = pc_ff;
               rsp_in.flags = cc_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign start_pc_in = csr_we ? csr_wdata : start_pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pc_ff <= lc3_exec_pkg::RESET_PC;
         cc_ff <= lc3_exec_pkg::FLAG_Z;
         start_pc_ff <= lc3_exec_pkg::RESET_PC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         pc_ff <= pc_in;
         cc_ff <= cc_in;
         start_pc_ff <= start_pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ir_ff <= ir_in;
      a_ff <= a_in;
      ea_ff <= ea_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= word_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         gen_reg[rf_waddr] <= rf_wdata;
      end
      if (rf_re) begin
         rf_q_ff <= gen_reg[rf_raddr];
      end
   end

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pc_after      = rsp_ff.pc_after;
   assign rsp_ch.executed_word = rsp_ff.executed_word;
   assign rsp_ch.flags         = rsp_ff.flags;
   assign rsp_ch.reg_written   = rsp_ff.reg_written;
   assign rsp_ch.reg_number    = rsp_ff.reg_number;
   assign rsp_ch.reg_value     = rsp_ff.reg_value;
   assign rsp_ch.mem_written   = rsp_ff.mem_written;
   assign rsp_ch.store_addr    = rsp_ff.store_addr;
   assign rsp_ch.store_data    = rsp_ff.store_data;
   assign rsp_ch.illegal       = rsp_ff.illegal;

   a_cc_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(cc_ff))
      else $error("condition code is not one-hot");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff != S_IDLE)
      else $error("request transaction accepted but sequencer stayed idle");

   a_store_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.mem_written |-> !rsp_ff.reg_written && !rsp_ff.illegal)
      else $error("store reported together with a register write or illegal opcode");

endmodule

`default_nettype wire
